>>> design/gn2d_pkg.sv
// Shared constants, types and functions of the 2D gradient noise unit.
package gn2d_pkg;

	localparam int AngleBits = 10;
	localparam int FracBits  = 16;
	localparam int Q14One    = 16384;
	localparam int QuarterSteps = 1 << (AngleBits - 2);

	localparam logic [1:0] RegFirst  = 2'd0;
	localparam logic [1:0] RegSecond = 2'd1;
	localparam logic [1:0] RegThird  = 2'd2;

	typedef logic signed [15:0] grad_t;

	// Gradient table: (cos, sin) in Q1.14 for each hash angle index.
	typedef struct packed {
		grad_t gx;
		grad_t gy;
	} grad_pair_t;

	typedef logic [QuarterSteps-1:0][14:0] sine_tab_t;

	function automatic logic [14:0] quarter_sine(input logic [14:0] u);
		logic [29:0] uu;
		logic [15:0] t2;
		logic signed [31:0] acc;
		logic signed [47:0] p;
		uu = u * u;
		t2 = uu[29:14];
		acc = 32'sd77;
		p = acc * $signed({1'b0, t2});
		acc = 32'sd1306 - 32'(p >>> 14);
		p = acc * $signed({1'b0, t2});
		acc = 32'sd10583 - 32'(p >>> 14);
		p = acc * $signed({1'b0, t2});
		acc = 32'sd25738 - 32'(p >>> 14);
		p = acc * $signed({1'b0, u});
		return 15'(p >>> 14);
	endfunction

	function automatic sine_tab_t build_sine_tab();
		sine_tab_t t;
		for (int k = 0; k < QuarterSteps; k++) begin
			t[k] = quarter_sine(15'(k << (16 - AngleBits)));
		end
		return t;
	endfunction

	// Quarter-wave sine at every angle step inside one quadrant.
	localparam sine_tab_t SineTab = build_sine_tab();

	function automatic grad_pair_t grad_lookup(input logic [AngleBits-1:0] idx);
		logic [AngleBits-3:0] k;
		logic [AngleBits-3:0] kc;
		grad_t sr;
		grad_t sc;
		grad_pair_t g;
		k = idx[AngleBits-3:0];
		kc = -k;
		sr = $signed({1'b0, SineTab[k]});
		// The complement of step zero is a full quarter turn, just past the table.
		if (k == '0) begin
			sc = grad_t'(Q14One);
		end else begin
			sc = $signed({1'b0, SineTab[kc]});
		end
		case (idx[AngleBits-1 -: 2])
			2'd0: begin g.gx = sc;  g.gy = sr;  end
			2'd1: begin g.gx = -sr; g.gy = sc;  end
			2'd2: begin g.gx = -sc; g.gy = -sr; end
			default: begin g.gx = sr; g.gy = -sc; end
		endcase
		return g;
	endfunction

endpackage

>>> design/gn2d_hash.sv
// Three-stage corner hash and gradient lookup for one lattice corner.
module gn2d_hash (
	input  logic clk,
	input  logic en,
	input  logic [31:0] ix,
	input  logic [31:0] iy,
	input  logic [31:0] mul_a,
	input  logic [31:0] mul_b,
	input  logic [31:0] mul_c,
	output gn2d_pkg::grad_pair_t grad
);
	import gn2d_pkg::*;

	logic [31:0] a_s1, iy_s1;
	logic [31:0] a_s2, b_s2;
	logic [31:0] h_s3;
	logic [31:0] b_mix;
	logic [31:0] a_mix;

	assign b_mix = iy_s1 ^ {a_s1[15:0], a_s1[31:16]};
	assign a_mix = a_s2 ^ {b_s2[15:0], b_s2[31:16]};
	assign grad = grad_lookup(h_s3[31 -: AngleBits]);

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1  <= 32'(ix * mul_a);
			iy_s1 <= iy;
			a_s2  <= a_s1;
			b_s2  <= 32'(b_mix * mul_b);
			h_s3  <= 32'(a_mix * mul_c);
		end
	end
endmodule

>>> design/gn2d_blend.sv
// Dot products and bilinear blend, four pipeline stages.
module gn2d_blend (
	input  logic clk,
	input  logic en,
	input  gn2d_pkg::grad_pair_t g00,
	input  gn2d_pkg::grad_pair_t g10,
	input  gn2d_pkg::grad_pair_t g01,
	input  gn2d_pkg::grad_pair_t g11,
	input  logic [gn2d_pkg::FracBits-1:0] fx,
	input  logic [gn2d_pkg::FracBits-1:0] fy,
	output logic signed [15:0] result
);
	import gn2d_pkg::*;

	localparam int DW = FracBits + 2;
	localparam int PW = DW + 16;

	logic signed [DW-1:0] dx0, dx1, dy0, dy1;
	logic signed [PW:0] d00_s1, d10_s1, d01_s1, d11_s1;
	logic [FracBits-1:0] fx_s1, fy_s1, fy_s2, fy_s3;
	logic signed [19:0] r0_s2, r1_s2, ya_s3, dd_s3;
	logic signed [PW-FracBits:0] n00, n10, n01, n11;
	logic signed [19:0] e00, e10, e01, e11;
	logic signed [20+FracBits:0] p0, p1, pv;
	logic signed [20:0] v;

	assign dx0 = $signed({2'b00, fx});
	assign dx1 = dx0 - $signed(DW'(1) << FracBits);
	assign dy0 = $signed({2'b00, fy});
	assign dy1 = dy0 - $signed(DW'(1) << FracBits);

	assign n00 = (PW-FracBits+1)'(d00_s1 >>> FracBits);
	assign n10 = (PW-FracBits+1)'(d10_s1 >>> FracBits);
	assign n01 = (PW-FracBits+1)'(d01_s1 >>> FracBits);
	assign n11 = (PW-FracBits+1)'(d11_s1 >>> FracBits);
	assign e00 = 20'(n00);
	assign e10 = 20'(n10);
	assign e01 = 20'(n01);
	assign e11 = 20'(n11);
	assign p0 = (e10 - e00) * $signed({1'b0, fx_s1});
	assign p1 = (e11 - e01) * $signed({1'b0, fx_s1});
	assign pv = dd_s3 * $signed({1'b0, fy_s3});
	assign v  = 21'(ya_s3) + 21'(pv >>> FracBits);

	always_ff @(posedge clk) begin
		if (en) begin
			d00_s1 <= dx0 * g00.gx + dy0 * g00.gy;
			d10_s1 <= dx1 * g10.gx + dy0 * g10.gy;
			d01_s1 <= dx0 * g01.gx + dy1 * g01.gy;
			d11_s1 <= dx1 * g11.gx + dy1 * g11.gy;
			fx_s1  <= fx;
			fy_s1  <= fy;
			r0_s2  <= e00 + 20'(p0 >>> FracBits);
			r1_s2  <= e01 + 20'(p1 >>> FracBits);
			fy_s2  <= fy_s1;
			ya_s3  <= r0_s2;
			dd_s3  <= r1_s2 - r0_s2;
			fy_s3  <= fy_s2;
			if (v > 21'sd32767) begin
				result <= 16'sh7fff;
			end else if (v < -21'sd32768) begin
				result <= -16'sh8000;
			end else begin
				result <= 16'(v);
			end
		end
	end
endmodule

>>> design/gradient_noise_2d_unit.sv
// Top level of the 2D gradient noise unit.
// Takes one point (x_coord, y_coord, signed fixed point) per cycle on the
// input channel while it is not stalled and returns one noise_value
// (signed Q1.14) per item on the output channel. Both channels move an
// item when valid is high and stall is low.
// The path is seven register stages deep: three for the corner hash, one
// for the gradient table and dot products, two for the x and y blends and
// one output register.
// Throughput is one item per cycle while the output is not stalled; the hash multipliers are pipelined.
// When the receiver stalls a valid output, the whole pipeline holds and
// in_stall rises, so nothing is lost or repeated. Reset clears the valid
// bits and the three multiplier registers. Write the multipliers through
// the cfg port while the unit is idle.
module gradient_noise_2d_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [31:0] x_coord,
	input  logic signed [31:0] y_coord,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [15:0] noise_value,
	input  logic cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [31:0] cfg_data
);
	import gn2d_pkg::*;

	localparam int Depth = 7;

	logic [31:0] mul_a_q, mul_b_q, mul_c_q;
	logic [Depth-1:0] vld_q;
	logic en;
	logic [31:0] x0, y0, x1, y1;
	logic [FracBits-1:0] fx_p [3], fy_p [3];
	logic [FracBits-1:0] fx_s3, fy_s3;
	grad_pair_t g00, g10, g01, g11;

	assign en = !(vld_q[Depth-1] && out_stall);
	assign in_stall = !en;
	assign out_valid = vld_q[Depth-1];

	assign x0 = 32'(x_coord >>> FracBits);
	assign y0 = 32'(y_coord >>> FracBits);
	assign x1 = x0 + 32'd1;
	assign y1 = y0 + 32'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			mul_a_q <= '0;
			mul_b_q <= '0;
			mul_c_q <= '0;
		end else begin
			if (en) begin
				vld_q <= {vld_q[Depth-2:0], in_valid};
			end
			if (cfg_we) begin
				unique case (cfg_index)
					RegFirst:  mul_a_q <= cfg_data;
					RegSecond: mul_b_q <= cfg_data;
					RegThird:  mul_c_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// Fractions ride alongside the three hash stages.
	always_ff @(posedge clk) begin
		if (en) begin
			fx_p[0] <= x_coord[FracBits-1:0];
			fy_p[0] <= y_coord[FracBits-1:0];
			fx_p[1] <= fx_p[0];
			fy_p[1] <= fy_p[0];
			fx_p[2] <= fx_p[1];
			fy_p[2] <= fy_p[1];
		end
	end
	assign fx_s3 = fx_p[2];
	assign fy_s3 = fy_p[2];

	gn2d_hash u_h00 (.clk, .en, .ix(x0), .iy(y0), .mul_a(mul_a_q), .mul_b(mul_b_q),
		.mul_c(mul_c_q), .grad(g00));
	gn2d_hash u_h10 (.clk, .en, .ix(x1), .iy(y0), .mul_a(mul_a_q), .mul_b(mul_b_q),
		.mul_c(mul_c_q), .grad(g10));
	gn2d_hash u_h01 (.clk, .en, .ix(x0), .iy(y1), .mul_a(mul_a_q), .mul_b(mul_b_q),
		.mul_c(mul_c_q), .grad(g01));
	gn2d_hash u_h11 (.clk, .en, .ix(x1), .iy(y1), .mul_a(mul_a_q), .mul_b(mul_b_q),
		.mul_c(mul_c_q), .grad(g11));

	gn2d_blend u_blend (
		.clk, .en, .g00, .g10, .g01, .g11,
		.fx(fx_s3), .fy(fy_s3), .result(noise_value)
	);
endmodule

>>> design/gn2d_checker.sv
// Port-level checker for the 2D gradient noise unit, bound to the top level.
module gn2d_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic signed [15:0] noise_value
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(noise_value))
		else $error("stalled result changed");

	a_in_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output stall");

	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid)
		else $error("result right after reset");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !out_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall
		##1 !out_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall |-> out_valid)
		else $error("item did not arrive after seven cycles");
endmodule

bind gradient_noise_2d_unit gn2d_checker u_gn2d_checker (
	.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .noise_value
);

>>> test/gradient_noise_2d_checker.sv
// Checker for the 2D gradient noise unit: predicts each noise value and compares.
module gradient_noise_2d_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_stall,
	input  logic signed [31:0] x_coord,
	input  logic signed [31:0] y_coord,
	input  logic out_valid,
	input  logic out_stall,
	input  logic signed [15:0] noise_value,
	input  logic cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [31:0] cfg_data,
	output int errors,
	output int pending
);
	import gn2d_pkg::*;

	logic [31:0] mult_x, mult_mix, mult_fin;
	logic signed [15:0] noise_q[$];

	// Quarter-wave sine polynomial, u in Q14, result 0..16384.
	function automatic longint qsine(input longint u);
		longint t2, acc;
		t2 = (u * u) >>> 14;
		acc = 77;
		acc = 1306 - ((acc * t2) >>> 14);
		acc = 10583 - ((acc * t2) >>> 14);
		acc = 25738 - ((acc * t2) >>> 14);
		return (acc * u) >>> 14;
	endfunction

	function automatic longint corner_dot(input logic [31:0] ix, input logic [31:0] iy,
			input longint dx, input longint dy);
		logic [31:0] a, b;
		logic [15:0] phase;
		longint r, sr, sc, gx, gy;
		a = ix * mult_x;
		b = iy ^ {a[15:0], a[31:16]};
		b = b * mult_mix;
		a = a ^ {b[15:0], b[31:16]};
		a = a * mult_fin;
		phase = 16'(a[31 -: AngleBits]) << (16 - AngleBits);
		r = phase[13:0];
		sr = qsine(r);
		sc = qsine(Q14One - r);
		case (phase[15:14])
			2'd0: begin gx = sc; gy = sr; end
			2'd1: begin gx = -sr; gy = sc; end
			2'd2: begin gx = -sc; gy = -sr; end
			default: begin gx = sr; gy = -sc; end
		endcase
		return (dx * gx + dy * gy) >>> FracBits;
	endfunction

	function automatic longint blend(input longint a, input longint b, input longint w);
		return a + (((b - a) * w) >>> FracBits);
	endfunction

	function automatic logic signed [15:0] predict_noise(input logic signed [31:0] xc,
			input logic signed [31:0] yc);
		longint one, fx, fy, n00, n10, n01, n11, v;
		logic [31:0] x0, y0;
		one = longint'(1) << FracBits;
		fx = xc & (one - 1);
		fy = yc & (one - 1);
		x0 = xc >>> FracBits;
		y0 = yc >>> FracBits;
		n00 = corner_dot(x0, y0, fx, fy);
		n10 = corner_dot(x0 + 1, y0, fx - one, fy);
		n01 = corner_dot(x0, y0 + 1, fx, fy - one);
		n11 = corner_dot(x0 + 1, y0 + 1, fx - one, fy - one);
		v = blend(blend(n00, n10, fx), blend(n01, n11, fx), fy);
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return 16'(v);
	endfunction

	assign pending = noise_q.size();

	always @(posedge clk or negedge arst_n) begin
		logic signed [15:0] want;
		if (!arst_n) begin
			mult_x <= '0;
			mult_mix <= '0;
			mult_fin <= '0;
			errors <= 0;
			noise_q.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (noise_q.size() == 0) begin
					if (errors < 10)
						$display("unexpected noise item %0d", noise_value);
					errors <= errors + 1;
				end else begin
					want = noise_q.pop_front();
					if (want !== noise_value) begin
						if (errors < 10)
							$display("noise mismatch: expected %0d got %0d", want, noise_value);
						errors <= errors + 1;
					end
				end
			end
			if (in_valid && !in_stall)
				noise_q.push_back(predict_noise(x_coord, y_coord));
			if (cfg_we) begin
				case (cfg_index)
					RegFirst: mult_x <= cfg_data;
					RegSecond: mult_mix <= cfg_data;
					RegThird: mult_fin <= cfg_data;
					default: ;
				endcase
			end
		end
	end

endmodule

>>> test/gradient_noise_2d_unit_tb.sv
// Testbench top for the 2D gradient noise unit: stimulus, stalls and verdict.
module gradient_noise_2d_unit_tb;
	import gn2d_pkg::*;

	logic clk, arst_n, in_valid, in_stall, out_valid, out_stall, cfg_we;
	logic signed [31:0] x_coord, y_coord;
	logic signed [15:0] noise_value;
	logic [1:0] cfg_index;
	logic [31:0] cfg_data;
	int errors, pending, cycles;
	bit calm;

	gradient_noise_2d_unit u_top (.*);
	gradient_noise_2d_checker u_chk (.*);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 200000) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Receiver stalls in random bursts until the calm tail of the run.
	initial begin
		out_stall = 0;
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				out_stall <= 1;
				repeat ($urandom_range(1, 8)) @(negedge clk);
			end
			out_stall <= 0;
		end
	end

	// Leaves the write enable high; the caller drops it after the last write.
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
	endtask

	task automatic load_seed(input logic [31:0] a, input logic [31:0] b, input logic [31:0] c);
		while (pending != 0) @(negedge clk);
		repeat (12) @(negedge clk);
		write_reg(RegFirst, a);
		write_reg(RegSecond, b);
		write_reg(RegThird, c);
		cfg_we <= 0;
	endtask

	// Sends one point; valid stays high when items follow back to back.
	task automatic send_point(input logic [31:0] xv, input logic [31:0] yv);
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		in_valid <= 1;
		x_coord <= xv;
		y_coord <= yv;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic random_point();
		logic [31:0] xv, yv;
		xv = $urandom();
		yv = $urandom();
		if ($urandom_range(0, 2) != 0) begin
			// Mostly points near the origin, within 128 cells of it on each axis.
			xv = 32'($signed(xv) >>> $urandom_range(8, 24));
			yv = 32'($signed(yv) >>> $urandom_range(8, 24));
		end
		send_point(xv, yv);
	endtask

	initial begin
		logic [31:0] seed;
		arst_n = 0;
		in_valid = 0;
		x_coord = 0;
		y_coord = 0;
		cfg_we = 0;
		cfg_index = RegFirst;
		cfg_data = 0;
		calm = 0;
		repeat (12) @(negedge clk);
		arst_n = 1;
		// Zero multipliers: every gradient is (1, 0).
		send_point(32'h0000_8000, 32'h0001_4000);
		send_point(32'h7FFF_FFFF, 32'h8000_0000);
		in_valid <= 0;
		load_seed(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		// Extreme cells at both ends of the coordinate range, then other patterns.
		send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_point(32'h8000_0000, 32'h8000_0000);
		send_point(32'h7FFF_0000, 32'h8000_FFFF);
		send_point(32'h0000_0000, 32'h0000_0000);
		send_point(32'hFFFF_FFFF, 32'h0000_FFFF);
		send_point(32'hAAAA_AAAA, 32'h5555_5555);
		send_point(32'h5555_5555, 32'hAAAA_AAAA);
		in_valid <= 0;
		seed = 32'd1337;
		load_seed(32'(seed * 105 / 100), 32'(seed * 85 / 100), 32'(seed * 115 / 100));
		for (int k = 0; k < 16; k++) begin
			send_point(32'(k) << 12, 32'(15 - k) << 12);
		end
		for (int ph = 0; ph < 5; ph++) begin
			in_valid <= 0;
			seed = $urandom();
			if (ph == 2)
				load_seed($urandom(), $urandom(), $urandom());
			else
				load_seed(32'((64'(seed) * 105) / 100), 32'((64'(seed) * 85) / 100),
					32'((64'(seed) * 115) / 100));
			if (ph == 4) calm = 1;
			for (int n = 0; n < 150; n++) random_point();
		end
		in_valid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
